FILE: rtl/core/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the recency-ordered key-value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  typedef logic [KEY_W-1:0]          key_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CAP_W-1:0]          cap_t;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_t;

  localparam value_t MISS_VALUE  = '1;
  localparam cap_t   CAP_RESET   = cap_t'(16);

  typedef struct packed {
    logic occupied;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/lrukv_cell.sv
// ----------------------------------------------------------------------------
// lrukv_cell
// One cache slot: holds a key/value pair, compares it against the lookup key
// and on a shift loads its left neighbor's pair, or the new pair at the head.
// ----------------------------------------------------------------------------
module lrukv_cell
  import lrukv_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  key_t       lookup_key,
  input  key_t       key_in,
  input  value_t     value_in,
  output key_t       key_out,
  output value_t     value_out,
  output logic       match
);

  key_t   key_r;
  value_t value_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key_r   <= key_in;
      value_r <= value_in;
    end
  end

  assign match     = ctrl.occupied && (key_r == lookup_key);
  assign key_out   = key_r;
  assign value_out = value_r;

endmodule

FILE: rtl/core/recency_ordered_key_value_cache.sv
// ----------------------------------------------------------------------------
// recency_ordered_key_value_cache
// Key-value cache kept as a row of slots ordered from newest to oldest set.
// ----------------------------------------------------------------------------
// One transaction is taken per clock whenever the result register is free or
// being drained: every slot compares its key with the incoming key in the
// same cycle, a set shifts the slots in front of the hit (or the oldest slot)
// one place back and writes the new pair into the front slot, and a get loads
// hit and value into the result register, visible the cycle after the
// transaction. A set gives no result. The input stalls only while a result
// waits under out_stall. A get leaves the order unchanged.
module recency_ordered_key_value_cache
  import lrukv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_wr_en,
  input  cap_t   cfg_wr_data,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_command,
  input  key_t   in_lookup_key,
  input  value_t in_store_value,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   out_hit,
  output value_t out_read_value
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  cap_t             cap_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  value_t           out_value_r, out_value_nxt;

  logic                   fire, set_fire, get_fire;
  logic [MAX_ENTRIES-1:0] match;
  key_t                   key_q   [MAX_ENTRIES];
  value_t                 value_q [MAX_ENTRIES];
  cell_ctrl_t             ctrl    [MAX_ENTRIES];
  logic [IDX_W-1:0]       hit_pos, last_pos;
  logic [EXT_W-1:0]       cap_eff, occ_ext;
  logic                   any_hit, full;
  value_t                 hit_value;

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;
  assign set_fire = fire && (cmd_t'(in_command) == CMD_SET);
  assign get_fire = fire && (cmd_t'(in_command) == CMD_GET);

  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_pos   = hit_pos | IDX_W'(i);
        hit_value = hit_value | value_q[i];
      end
    end
  end

  assign any_hit = |match;

  always_comb begin
    cap_eff = EXT_W'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = EXT_W'(1);
    end else if (cap_eff > EXT_W'(MAX_ENTRIES)) begin
      cap_eff = EXT_W'(MAX_ENTRIES);
    end
  end

  assign occ_ext = EXT_W'(occ_r);
  assign full    = occ_ext >= cap_eff;

  always_comb begin
    occ_nxt = occ_r;
    if (any_hit) begin
      last_pos = hit_pos;
    end else if (full) begin
      last_pos = IDX_W'(occ_r - OCC_W'(1));
    end else begin
      last_pos = IDX_W'(occ_r);
      if (set_fire) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    key_t   key_in;
    value_t value_in;

    assign ctrl[g].occupied = OCC_W'(g) < occ_r;
    assign ctrl[g].shift    = set_fire && (IDX_W'(g) <= last_pos);

    if (g == 0) begin : g_head
      assign key_in   = in_lookup_key;
      assign value_in = in_store_value;
    end else begin : g_body
      assign key_in   = key_q[g-1];
      assign value_in = value_q[g-1];
    end

    lrukv_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .lookup_key (in_lookup_key),
      .key_in     (key_in),
      .value_in   (value_in),
      .key_out    (key_q[g]),
      .value_out  (value_q[g]),
      .match      (match[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_value_nxt = out_value_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (get_fire) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = any_hit;
      out_value_nxt = any_hit ? hit_value : MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r   <= out_hit_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(MAX_ENTRIES))
    else $error("occupancy above slot count");

  a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key held in more than one slot");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    get_fire |=> out_valid_r)
    else $error("get transaction produced no result");

  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != occ_nxt) |-> (set_fire && !any_hit && !full))
    else $error("occupancy changed without an inserting set");

endmodule
